### rtl/core/lsh_pkg.sv
package lsh_pkg;

  // Build-time defaults
  localparam int unsigned LshMaxWidth    = 1024;
  localparam int unsigned LshMaxChannels = 3;

  // Fixed field widths
  localparam int unsigned LshRowW   = 16;
  localparam int unsigned LshPaddrW = 4;
  localparam int unsigned LshDataW  = 32;

  // Register map, index = paddr[3:2]
  localparam logic [1:0] RegImageWidth   = 2'd0;
  localparam logic [1:0] RegImageHeight  = 2'd1;
  localparam logic [1:0] RegChannelCount = 2'd2;

  localparam logic [10:0] ImageWidthReset   = 11'd640;
  localparam logic [15:0] ImageHeightReset  = 16'd480;
  localparam logic [1:0]  ChannelCountReset = 2'd3;

  // Item kinds
  localparam logic CmdPixel = 1'b0;
  localparam logic CmdDrain = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_ch0;
    logic [7:0] in_ch1;
    logic [7:0] in_ch2;
  } lsh_in_t;

  typedef struct packed {
    logic [7:0] out_ch0;
    logic [7:0] out_ch1;
    logic [7:0] out_ch2;
    logic       frame_end;
  } lsh_out_t;

  typedef struct packed {
    logic [10:0] image_width;
    logic [15:0] image_height;
    logic [1:0]  channel_count;
  } lsh_cfg_t;

  // Per-item decision handed from the position tracker to the window stage
  typedef struct packed {
    logic pixel;
    logic res_valid;
    logic interior;
    logic frame_end;
  } lsh_op_t;

endpackage

### rtl/core/lsh_ram.sv
module lsh_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read returns the old content on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/lsh_cfg.sv
module lsh_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lsh_pkg::LshPaddrW-1:0] paddr,
  input  logic [lsh_pkg::LshDataW-1:0]  pwdata,
  output logic [lsh_pkg::LshDataW-1:0]  prdata,
  output logic                          pready,
  output lsh_pkg::lsh_cfg_t             cfg_o
);
  import lsh_pkg::*;

  logic [10:0] width_q;
  logic [15:0] height_q;
  logic [1:0]  chan_q;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ImageWidthReset;
      height_q <= ImageHeightReset;
      chan_q   <= ChannelCountReset;
    end else if (wr_en) begin
      case (reg_idx)
        RegImageWidth:   width_q  <= pwdata[10:0];
        RegImageHeight:  height_q <= pwdata[15:0];
        RegChannelCount: chan_q   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegImageWidth:   prdata = {21'd0, width_q};
      RegImageHeight:  prdata = {16'd0, height_q};
      RegChannelCount: prdata = {30'd0, chan_q};
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = '{image_width: width_q, image_height: height_q, channel_count: chan_q};

endmodule

### rtl/core/lsh_ctrl.sv
module lsh_ctrl #(
  parameter int unsigned MaxWidth = lsh_pkg::LshMaxWidth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lsh_pkg::lsh_cfg_t           cfg_i,
  input  logic                        accept_i,
  input  logic                        cmd_i,
  output lsh_pkg::lsh_op_t            op_o,
  output logic [$clog2(MaxWidth)-1:0] col_o
);
  import lsh_pkg::*;

  localparam int unsigned ColW = $clog2(MaxWidth);
  localparam int unsigned WW   = $clog2(MaxWidth + 1);

  logic [ColW-1:0]    col_q, col_d;
  logic [LshRowW-1:0] row_q, row_d;
  logic [WW-1:0]      drain_q, drain_d;

  logic [WW-1:0]      eff_w;
  logic [LshRowW-1:0] eff_h;
  logic [WW:0]        w_plus1;
  logic [WW:0]        drain_inc;
  logic [ColW-1:0]    pos_col;
  logic [LshRowW-1:0] pos_row;
  logic [WW-1:0]      col_inc;
  lsh_op_t            op;

  always_comb begin
    if (cfg_i.image_width == 11'd0) begin
      eff_w = WW'(1);
    end else if (32'(cfg_i.image_width) > MaxWidth) begin
      eff_w = WW'(MaxWidth);
    end else begin
      eff_w = WW'(cfg_i.image_width);
    end
    eff_h = (cfg_i.image_height == '0) ? LshRowW'(1) : cfg_i.image_height;
  end

  assign w_plus1   = {1'b0, eff_w} + (WW+1)'(1);
  assign drain_inc = {1'b0, drain_q} + (WW+1)'(1);

  always_comb begin
    op      = '0;
    col_d   = col_q;
    row_d   = row_q;
    drain_d = drain_q;
    pos_col = col_q;
    pos_row = row_q;
    col_inc = '0;
    if (cmd_i == CmdPixel) begin
      op.pixel = 1'b1;
      // A finished frame restarts; a column past a narrowed width wraps
      if (row_q >= eff_h) begin
        pos_col = '0;
        pos_row = '0;
        drain_d = '0;
      end else if (WW'(col_q) >= eff_w) begin
        pos_col = '0;
        pos_row = row_q + LshRowW'(1);
        if (pos_row >= eff_h) begin
          pos_row = '0;
          drain_d = '0;
        end
      end
      op.res_valid = (pos_row >= LshRowW'(2)) ||
                     ((pos_row == LshRowW'(1)) && (pos_col != '0));
      op.interior  = (pos_row >= LshRowW'(2)) && (pos_col >= ColW'(2));
      col_inc = WW'(pos_col) + WW'(1);
      if (col_inc >= eff_w) begin
        col_d = '0;
        row_d = pos_row + LshRowW'(1);
      end else begin
        col_d = col_inc[ColW-1:0];
        row_d = pos_row;
      end
    end else if (row_q >= eff_h) begin
      if ({1'b0, drain_q} >= w_plus1) begin
        col_d   = '0;
        row_d   = '0;
        drain_d = '0;
      end else begin
        // Short frames have no result for the first drain tick
        op.res_valid = (eff_h >= LshRowW'(2)) || (drain_q != '0);
        op.frame_end = (drain_q == eff_w);
        if (drain_inc >= w_plus1) begin
          col_d   = '0;
          row_d   = '0;
          drain_d = '0;
        end else begin
          drain_d = drain_inc[WW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      drain_q <= '0;
    end else if (accept_i) begin
      col_q   <= col_d;
      row_q   <= row_d;
      drain_q <= drain_d;
    end
  end

  assign op_o  = op;
  assign col_o = pos_col;

endmodule

### rtl/core/lsh_window.sv
module lsh_window #(
  parameter int unsigned MaxWidth    = lsh_pkg::LshMaxWidth,
  parameter int unsigned MaxChannels = lsh_pkg::LshMaxChannels,
  localparam int unsigned NumLanes   = (MaxChannels < 3) ? MaxChannels : 3,
  localparam int unsigned PixW       = 8 * NumLanes,
  localparam int unsigned ColW       = $clog2(MaxWidth)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lsh_pkg::lsh_cfg_t cfg_i,
  input  logic              accept_i,
  input  lsh_pkg::lsh_op_t  op_i,
  input  logic [ColW-1:0]   col_i,
  input  lsh_pkg::lsh_in_t  in_data_i,
  input  logic [2*PixW-1:0] ram_rdata_i,
  output logic              ram_we_o,
  output logic [ColW-1:0]   ram_waddr_o,
  output logic [2*PixW-1:0] ram_wdata_o,
  output logic              ready_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lsh_pkg::lsh_out_t out_data_o
);
  import lsh_pkg::*;

  function automatic logic [7:0] sharpen(input logic [7:0] c, input logic [7:0] u,
                                         input logic [7:0] d, input logic [7:0] l,
                                         input logic [7:0] r);
    logic [11:0] acc;
    acc = {2'b00, c, 2'b00} + {4'd0, c} - {4'd0, u} - {4'd0, d} - {4'd0, l} - {4'd0, r};
    if (acc[11]) begin
      return 8'd0;
    end else if (acc[10:8] != 3'd0) begin
      return 8'hFF;
    end else begin
      return acc[7:0];
    end
  endfunction

  logic              b_valid_q;
  lsh_op_t           b_op_q;
  logic [ColW-1:0]   b_col_q;
  logic [PixW-1:0]   b_px_q;
  logic              fwd_q;
  logic [2*PixW-1:0] fwd_data_q;
  logic [PixW-1:0]   w11_q, w02_q, w12_q, w22_q;
  logic              out_valid_q;
  lsh_out_t          out_q, out_d;

  logic [23:0]       px_full;
  logic [2*PixW-1:0] line;
  logic [PixW-1:0]   up, mid;
  logic              o_free, b_go, b_leave;
  logic [7:0]        res_ch [3];
  logic [1:0]        nch;

  assign px_full = {in_data_i.in_ch2, in_data_i.in_ch1, in_data_i.in_ch0};

  // Same column written by the leaving item: take its data, not the stale read
  assign line = fwd_q ? fwd_data_q : ram_rdata_i;
  assign up   = line[2*PixW-1:PixW];
  assign mid  = line[PixW-1:0];

  assign o_free  = !out_valid_q || !out_stall_i;
  assign b_go    = o_free || !b_op_q.res_valid;
  assign b_leave = b_valid_q && b_go;
  assign ready_o = !b_valid_q || b_go;

  assign ram_we_o    = b_leave && b_op_q.pixel;
  assign ram_waddr_o = b_col_q;
  assign ram_wdata_o = {mid, b_px_q};

  assign nch = (32'(cfg_i.channel_count) > NumLanes) ? 2'(NumLanes) : cfg_i.channel_count;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      res_ch[k] = 8'd0;
    end
    for (int k = 0; k < NumLanes; k++) begin
      if (b_op_q.interior && (k < 32'(nch))) begin
        res_ch[k] = sharpen(w12_q[8*k +: 8], w02_q[8*k +: 8], w22_q[8*k +: 8],
                            w11_q[8*k +: 8], mid[8*k +: 8]);
      end
    end
    out_d = '{out_ch0: res_ch[0], out_ch1: res_ch[1], out_ch2: res_ch[2],
              frame_end: b_op_q.frame_end};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (ready_o) begin
      b_valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      b_op_q     <= op_i;
      b_col_q    <= col_i;
      b_px_q     <= px_full[PixW-1:0];
      fwd_q      <= ram_we_o && op_i.pixel && (col_i == b_col_q);
      fwd_data_q <= ram_wdata_o;
    end
  end

  // Advance the window once per pixel as it leaves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w11_q <= '0;
      w02_q <= '0;
      w12_q <= '0;
      w22_q <= '0;
    end else if (ram_we_o) begin
      w11_q <= w12_q;
      w02_q <= up;
      w12_q <= mid;
      w22_q <= b_px_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (o_free) begin
      out_valid_q <= b_leave && b_op_q.res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_leave && b_op_q.res_valid) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_frame_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.frame_end |->
      (out_q.out_ch0 == 8'd0) && (out_q.out_ch1 == 8'd0) && (out_q.out_ch2 == 8'd0))
    else $error("frame end result carries nonzero channels");

  a_interior_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && b_op_q.interior |-> b_op_q.pixel && b_op_q.res_valid)
    else $error("interior result from a non-pixel item");

  a_hold_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && !b_go |=> b_valid_q)
    else $error("pending item dropped while output blocked");
`endif

endmodule

### rtl/core/laplacian_sharpen_3x3_core.sv
// 3x3 Laplacian sharpen over a raster-order pixel stream.
// Input channel: in_valid_i / in_stall_o with in_data_i. cmd = 0 carries a
// pixel of the frame, cmd = 1 is a drain tick; after the last pixel send
// width+1 drain ticks to flush the border results still pending.
// Output channel: out_valid_o / out_stall_i with out_data_o; frame_end marks
// the last result of a frame. Results trail their pixels by one row plus one
// pixel of the stream; border pixels and unused channels come out as zero.
// An item is registered in the window stage and its result in the output register.
// Throughput: one item per cycle unless the output stalls. Both line buffers
// share one memory entry per column, read at acceptance and written back as
// the item leaves the window stage, so a column is touched once per item;
// same-column back-to-back items are forwarded.
// Stall: a stalled output holds its result while one further item is taken
// into the window stage; the input stalls only once that stage is full too.
// Reset: counters and window clear, registers return to 640 x 480, 3 channels.
// Line memory content is not cleared; it only feeds border positions before
// it has been written. Configure over the APB port while the stream is idle.
module laplacian_sharpen_3x3_core #(
  parameter int unsigned MaxWidth    = lsh_pkg::LshMaxWidth,
  parameter int unsigned MaxChannels = lsh_pkg::LshMaxChannels
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  lsh_pkg::lsh_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lsh_pkg::lsh_out_t             out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lsh_pkg::LshPaddrW-1:0] paddr,
  input  logic [lsh_pkg::LshDataW-1:0]  pwdata,
  output logic [lsh_pkg::LshDataW-1:0]  prdata,
  output logic                          pready
);
  import lsh_pkg::*;

  localparam int unsigned NumLanes = (MaxChannels < 3) ? MaxChannels : 3;
  localparam int unsigned PixW     = 8 * NumLanes;
  localparam int unsigned ColW     = $clog2(MaxWidth);

  lsh_cfg_t          cfg;
  lsh_op_t           op;
  logic [ColW-1:0]   col;
  logic              win_ready;
  logic              accept;
  logic              ram_we;
  logic [ColW-1:0]   ram_waddr;
  logic [2*PixW-1:0] ram_wdata;
  logic [2*PixW-1:0] ram_rdata;

  assign accept     = in_valid_i && win_ready;
  assign in_stall_o = !win_ready;

  lsh_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lsh_ctrl #(
    .MaxWidth (MaxWidth)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .accept_i (accept),
    .cmd_i    (in_data_i.cmd),
    .op_o     (op),
    .col_o    (col)
  );

  // Entry per column: {upper line, middle line}
  lsh_ram #(
    .Width (2 * PixW),
    .Depth (MaxWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept && op.pixel),
    .raddr_i (col),
    .rdata_o (ram_rdata)
  );

  lsh_window #(
    .MaxWidth    (MaxWidth),
    .MaxChannels (MaxChannels)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .accept_i    (accept),
    .op_i        (op),
    .col_i       (col),
    .in_data_i   (in_data_i),
    .ram_rdata_i (ram_rdata),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ready_o     (win_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### tb/laplacian_sharpen_3x3_core_test.sv
`timescale 1ns / 100ps

module laplacian_sharpen_3x3_core_test;
  import lsh_pkg::*;

  localparam int unsigned HoldCycles = 80;
  localparam int unsigned IdleTail   = 8;
  localparam int unsigned LongRow    = 64;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  lsh_in_t              in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  lsh_out_t             out_data_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [LshPaddrW-1:0] paddr;
  logic [LshDataW-1:0]  pwdata;
  logic [LshDataW-1:0]  prdata;
  logic                 pready;

  laplacian_sharpen_3x3_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Shadow of the block: registers, line memories, window and raster position
  logic [10:0]  width_reg  = ImageWidthReset;
  logic [15:0]  height_reg = ImageHeightReset;
  logic [1:0]   chan_reg   = ChannelCountReset;
  bit [23:0]    upper_row [LshMaxWidth];
  bit [23:0]    middle_row [LshMaxWidth];
  bit [23:0]    win [3][3];
  int unsigned  col_pos   = 0;
  int unsigned  row_pos   = 0;
  int unsigned  drain_pos = 0;

  lsh_out_t     sharpened_q [$];
  int unsigned  mismatch_count = 0;
  bit           tx_gaps   = 1'b1;
  bit           rx_stalls = 1'b1;
  int unsigned  hold_requests = 0;
  int unsigned  holds_done    = 0;

  function automatic int unsigned cur_w();
    if (width_reg == 0) return 1;
    if (width_reg > LshMaxWidth) return LshMaxWidth;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned cur_h();
    return (height_reg == 0) ? 1 : 32'(height_reg);
  endfunction

  function automatic void frame_restart();
    col_pos   = 0;
    row_pos   = 0;
    drain_pos = 0;
  endfunction

  function automatic int chan_of(bit [23:0] px, int unsigned c);
    return int'(px[8*c +: 8]);
  endfunction

  // Queue the result for raster position n - w - 1, if that position exists
  function automatic void emit_sharpened(int unsigned n, int unsigned w, int unsigned h,
                                         bit from_window);
    int unsigned p, pr, pc, c;
    int          v;
    bit [7:0]    ch [3];
    lsh_out_t    px_out;
    if (n < w + 1) return;
    p  = n - w - 1;
    pr = p / w;
    pc = p % w;
    ch = '{default: 8'd0};
    if (from_window && pr != 0 && pr + 1 < h && pc != 0 && pc + 1 < w) begin
      for (c = 0; c < chan_reg; c++) begin
        v = 5 * chan_of(win[1][1], c) - chan_of(win[0][1], c) - chan_of(win[2][1], c)
            - chan_of(win[1][0], c) - chan_of(win[1][2], c);
        if (v < 0) begin
          v = 0;
        end else if (v > 255) begin
          v = 255;
        end
        ch[c] = v[7:0];
      end
    end
    px_out.out_ch0   = ch[0];
    px_out.out_ch1   = ch[1];
    px_out.out_ch2   = ch[2];
    px_out.frame_end = (p == w * h - 1);
    sharpened_q.push_back(px_out);
  endfunction

  task automatic sharpen_predict(input lsh_in_t item);
    int unsigned w, h, r;
    bit [23:0]   px, up, mid;
    w = cur_w();
    h = cur_h();
    if (item.cmd == CmdDrain) begin
      if (row_pos < h) return;
      if (drain_pos >= w + 1) begin
        frame_restart();
        return;
      end
      emit_sharpened(h * w + drain_pos, w, h, 1'b0);
      drain_pos++;
      if (drain_pos >= w + 1) frame_restart();
      return;
    end
    if (row_pos >= h) frame_restart();
    // a column left beyond a narrowed row wraps to the next row
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) frame_restart();
    end
    px  = {item.in_ch2, item.in_ch1, item.in_ch0};
    up  = upper_row[col_pos];
    mid = middle_row[col_pos];
    for (r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = up;
    win[1][2] = mid;
    win[2][2] = px;
    upper_row[col_pos]  = mid;
    middle_row[col_pos] = px;
    emit_sharpened(row_pos * w + col_pos, w, h, 1'b1);
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
  endtask

  function automatic int unsigned idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic lsh_in_t make_item(input logic kind);
    lsh_in_t item;
    item.cmd    = kind;
    item.in_ch0 = pick_sample();
    item.in_ch1 = pick_sample();
    item.in_ch2 = pick_sample();
    return item;
  endfunction

  task automatic send_item(input lsh_in_t item);
    int unsigned gap;
    gap = (tx_gaps && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    sharpen_predict(item);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [LshDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegImageWidth:   width_reg  = value[10:0];
      RegImageHeight:  height_reg = value[15:0];
      RegChannelCount: chan_reg   = value[1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop valid, let every pending result out, then give the pipe time to empty
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sharpened_q.size() != 0) @(posedge clk_i);
    repeat (IdleTail) @(posedge clk_i);
  endtask

  task automatic test_clamp_and_drain();
    logic [7:0]  grid [12];
    lsh_in_t     item;
    int unsigned k;
    // center 255 among zeros, and center 0 among 255s, on the two interior pixels
    grid = '{8'd0, 8'd0, 8'd255, 8'd0,
             8'd0, 8'd255, 8'd0, 8'd255,
             8'd0, 8'd0, 8'd255, 8'd0};
    apb_write(RegImageWidth, 4);
    apb_write(RegImageHeight, 3);
    apb_write(RegChannelCount, 3);
    for (k = 0; k < 12; k++) begin
      item.cmd    = CmdPixel;
      item.in_ch0 = grid[k];
      item.in_ch1 = ~grid[k];
      item.in_ch2 = grid[k] ^ 8'h3C;
      send_item(item);
      // inside the frame a drain tick is ignored
      if (k == 5) send_item(make_item(CmdDrain));
    end
    repeat (5) send_item(make_item(CmdDrain));
    send_item(make_item(CmdDrain));
    wait_idle();
  endtask

  task automatic test_short_frames();
    apb_write(RegImageWidth, 0);
    apb_write(RegImageHeight, 0);
    apb_write(RegChannelCount, 0);
    send_item(make_item(CmdPixel));
    repeat (2) send_item(make_item(CmdDrain));
    wait_idle();
    apb_write(RegImageWidth, 2);
    repeat (2) send_item(make_item(CmdPixel));
    repeat (2) send_item(make_item(CmdDrain));
    // a pixel in the middle of the drain starts a new frame
    repeat (2) send_item(make_item(CmdPixel));
    repeat (3) send_item(make_item(CmdDrain));
    wait_idle();
  endtask

  task automatic test_midframe_reshape();
    apb_write(RegImageWidth, 6);
    apb_write(RegImageHeight, 32'hFFFF);
    apb_write(RegChannelCount, 2);
    repeat (23) send_item(make_item(CmdPixel));
    wait_idle();
    // column 5 is now past the row end and wraps
    apb_write(RegImageWidth, 4);
    repeat (8) send_item(make_item(CmdPixel));
    wait_idle();
    apb_write(RegImageHeight, 3);
    apb_write(RegChannelCount, 1);
    repeat (5) send_item(make_item(CmdDrain));
    wait_idle();
  endtask

  task automatic test_backpressure();
    apb_write(RegImageWidth, 8);
    apb_write(RegImageHeight, 6);
    apb_write(RegChannelCount, 3);
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    hold_requests++;
    repeat (48) send_item(make_item(CmdPixel));
    repeat (9) send_item(make_item(CmdDrain));
    wait_idle();
  endtask

  task automatic test_random_frames(input int unsigned target);
    int unsigned sent, nd, frame_px, reshape_at, sel;
    sent = 0;
    while (sent < target) begin
      // reprogram only between frames, with the raster position back at the origin
      if (row_pos == 0 && col_pos == 0 && drain_pos == 0) begin
        wait_idle();
        tx_gaps   = ($urandom_range(0, 3) != 0);
        rx_stalls = ($urandom_range(0, 3) != 0);
        sel = $urandom_range(0, 15);
        apb_write(RegImageWidth, (sel == 0) ? 0 :
                                 (sel < 3)  ? $urandom_range(13, 40) : $urandom_range(1, 12));
        apb_write(RegImageHeight, $urandom_range(0, 8));
        apb_write(RegChannelCount, $urandom_range(0, 3));
      end
      reshape_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, cur_w() * cur_h()) : 0;
      frame_px = 0;
      do begin
        if (row_pos < cur_h() && $urandom_range(0, 19) == 0) begin
          send_item(make_item(CmdDrain));
        end
        send_item(make_item(CmdPixel));
        frame_px++;
        if (frame_px == reshape_at) begin
          wait_idle();
          // shrink only: wider rows would read line entries never written
          apb_write(RegImageWidth, $urandom_range(1, cur_w()));
          apb_write(RegImageHeight, $urandom_range(0, 8));
        end
      end while (row_pos < cur_h());
      sent += frame_px;
      sel = $urandom_range(0, 9);
      nd  = (sel == 0) ? $urandom_range(0, cur_w()) : cur_w() + 1;
      repeat (nd) send_item(make_item(CmdDrain));
      sent += nd;
      if (sel == 1) repeat ($urandom_range(1, 2)) send_item(make_item(CmdDrain));
    end
    while (row_pos != 0 || col_pos != 0 || drain_pos != 0) send_item(make_item(CmdDrain));
    wait_idle();
  endtask

  task automatic test_long_row();
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    apb_write(RegImageWidth, LongRow);
    apb_write(RegImageHeight, 3);
    apb_write(RegChannelCount, 3);
    repeat (3 * LongRow) send_item(make_item(CmdPixel));
    repeat (LongRow + 1) send_item(make_item(CmdDrain));
    wait_idle();
  endtask

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    lsh_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sharpened_q.size() == 0) begin
        $error("unexpected result transfer: %h", out_data_o);
        mismatch_count++;
      end else begin
        want = sharpened_q.pop_front();
        check_field("out_ch0", want.out_ch0, out_data_o.out_ch0);
        check_field("out_ch1", want.out_ch1, out_data_o.out_ch1);
        check_field("out_ch2", want.out_ch2, out_data_o.out_ch2);
        check_field("frame_end", 8'(want.frame_end), 8'(out_data_o.frame_end));
      end
    end
  end

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver: random stalls, or one long hold-off on request
  initial begin
    int unsigned len;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_done != hold_requests) begin
        holds_done++;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
        len = idle_len();
        out_stall_i <= 1'b1;
        repeat (len) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    #3_000_000;
    $display("laplacian_sharpen_3x3_core verification failed");
    $finish;
  end

  initial begin
    in_valid_i = 1'b0;
    in_data_i  = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    rst_ni     = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_clamp_and_drain();
    test_short_frames();
    test_midframe_reshape();
    test_backpressure();
    test_random_frames(460);
    test_long_row();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("laplacian_sharpen_3x3_core verification clean");
    end else begin
      $display("laplacian_sharpen_3x3_core verification failed");
    end
    $finish;
  end

endmodule
